// ===== rtl/core/reversible_deque_engine_assert.svh =====
// Assertion macros for the reversible deque engine.
// Used by the top level; no other dependencies.
// Each macro is empty when SYNTHESIS is defined.
`ifndef REVERSIBLE_DEQUE_ENGINE_ASSERT_SVH
`define REVERSIBLE_DEQUE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset.
`define RDE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rde assertion failed: always");

// Check that an antecedent implies a consequent in the same cycle.
`define RDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rde assertion failed: implication");

// Check that an antecedent implies a consequent in the next cycle.
`define RDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rde assertion failed: next cycle");

`else

`define RDE_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define RDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RDE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/rde_pkg.sv =====
// Shared types, constants and helpers for the reversible deque engine.
// No dependencies.
package rde_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 16;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1) > 0 ? $clog2(DEPTH + 1) : 1;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 16;
    localparam int IN_W     = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 3'd0,
        MODE_LOAD    = 3'd1,
        MODE_REVERSE = 3'd2,
        MODE_DELETE  = 3'd3,
        MODE_DUMP    = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ELEM  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // Ring index arithmetic: both operands are below DEPTH.
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/rde_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rde_ram #(
    parameter int DATA_W     = 16,
    parameter int ADDR_DEPTH = 64,
    parameter int ADDR_W_L   = (ADDR_DEPTH > 1) ? $clog2(ADDR_DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [ADDR_W_L-1:0]    waddr,
    input  logic [DATA_W-1:0]      wdata,
    input  logic                   re,
    input  logic [ADDR_W_L-1:0]    raddr,
    output logic [DATA_W-1:0]      rdata
);
    logic [DATA_W-1:0] mem [ADDR_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/reversible_deque_engine.sv =====
// Reversible deque engine: ring-buffer deque in one synchronous RAM, with a reverse flag.
// Timing: clear, load, reverse and delete take effect at the accepting edge; an empty or
//   error dump shows its result the cycle after acceptance; dump elements pass the RAM read
//   register and output register, one per cycle while out_ready is high. Throughput: one
//   command per cycle when idle and the output slot is free; a dump holds the input until
//   its last element is registered. Reset (rst_n, async) clears pointers, count and flags.
module reversible_deque_engine
    import rde_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MODE_W-1:0]     mode,
    input  logic [IN_W-1:0]       value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [OUT_W-1:0]      value_res,
    output logic                  last
);
    `include "reversible_deque_engine_assert.svh"

    // ------------------------------------------------------------------
    // Architectural state: head pointer, element count, flags.
    // The element store itself lives in the RAM below.
    // ------------------------------------------------------------------
    logic [PTR_W-1:0]      head_reg,  head_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic                  rev_reg,   rev_next;
    logic                  err_reg,   err_next;
    state_t                state_reg, state_next;

    // Dump sequencer: number of reads issued, and the read beat waiting in the RAM
    // output register together with its final-element mark.
    logic [CNT_W-1:0]      idx_reg,       idx_next;
    logic                  pend_reg,      pend_next;
    logic                  pend_last_reg, pend_last_next;

    // Output register: holds one result beat until the consumer takes it.
    logic                  out_valid_reg,  out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [OUT_W-1:0]      out_value_reg,  out_value_next;
    logic                  out_last_reg,   out_last_next;

    // RAM port signals
    logic                  ram_we;
    logic [PTR_W-1:0]      ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [PTR_W-1:0]      ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic                  dumping;
    logic                  out_free;
    logic                  accept;
    logic                  take;
    logic                  issue;
    logic [PTR_W-1:0]      dump_off;
    logic [31:0]           value_wide;
    logic [31:0]           rdata_wide;

    // Input value masked to the stored width, RAM data cut to the 16-bit result.
    assign value_wide = 32'(value);
    assign ram_wdata  = value_wide[VALUE_BITS-1:0];
    assign rdata_wide = 32'(ram_rdata);

    assign dumping = (state_reg == S_DUMP);

    // The output slot frees up when empty or when the current beat leaves.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !dumping && out_free;
    assign accept   = in_valid && in_ready;

    // Dump sequencing: move the waiting RAM beat into the output register, and
    // keep one read in flight so elements stream at one per cycle while out_ready is high.
    assign take  = dumping && pend_reg && out_free;
    assign issue = dumping && (idx_reg < cnt_reg) && (!pend_reg || take);

    // Reverse order walks the logical offsets from the back.
    assign dump_off = rev_reg ? PTR_W'(cnt_reg - idx_reg - CNT_W'(1)) : PTR_W'(idx_reg);

    always_comb
    begin
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        rev_next        = rev_reg;
        err_next        = err_reg;
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = wrap_add(head_reg, PTR_W'(cnt_reg));
        ram_re          = 1'b0;
        ram_raddr       = wrap_add(head_reg, dump_off);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_CLEAR:
                        begin
                            head_next = '0;
                            cnt_next  = '0;
                            rev_next  = 1'b0;
                            err_next  = 1'b0;
                        end
                        MODE_LOAD:
                        begin
                            // drop the load when the store is full
                            if (cnt_reg < CNT_W'(DEPTH))
                            begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        MODE_REVERSE:
                        begin
                            if (!err_reg)
                            begin
                                rev_next = !rev_reg;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (!err_reg)
                            begin
                                if (cnt_reg == '0)
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    // reversed front is the physical back: head stays
                                    if (!rev_reg)
                                    begin
                                        head_next = wrap_add(head_reg, PTR_W'(1));
                                    end
                                    cnt_next = cnt_reg - CNT_W'(1);
                                end
                            end
                        end
                        MODE_DUMP:
                        begin
                            if (err_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_ERROR;
                                out_value_next  = '0;
                                out_last_next   = 1'b1;
                            end
                            else if (cnt_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_EMPTY;
                                out_value_next  = '0;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                                idx_next   = '0;
                                pend_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            // unused modes: no effect, no result
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (take)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_ELEM;
                    out_value_next  = rdata_wide[OUT_W-1:0];
                    out_last_next   = pend_last_reg;
                    pend_next       = 1'b0;
                    if (pend_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if (issue)
                begin
                    ram_re         = 1'b1;
                    idx_next       = idx_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                    pend_last_next = (idx_reg == cnt_reg - CNT_W'(1));
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            rev_reg       <= 1'b0;
            err_reg       <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            rev_reg       <= rev_next;
            err_reg       <= err_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: no reset needed.
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    // Element store. Writes happen only in idle and reads only during a dump,
    // so the two ports never touch the same entry in the same cycle.
    rde_ram #(
        .DATA_W     (VALUE_BITS),
        .ADDR_DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign value_res = out_value_reg;
    assign last      = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RDE_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(DEPTH))
    `RDE_ASSERT_IMPLIES(a_dump_nonempty, clk, rst_n, dumping, cnt_reg != '0 && !err_reg)
    `RDE_ASSERT_IMPLIES(a_pend_in_dump, clk, rst_n, pend_reg, dumping)
    `RDE_ASSERT_NEXT(a_dump_hold, clk, rst_n, dumping, $stable({cnt_reg, head_reg, rev_reg}))

endmodule

// ===== tb/sv/rde_dump_checker.sv =====
// Checker for the reversible deque engine: tracks the deque from the command channel,
// predicts every dump beat and compares it with the result channel.
// Depends on rde_pkg for widths, depth, modes and status codes.
`timescale 1ns / 100ps

module rde_dump_checker
    import rde_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [MODE_W-1:0]     mode,
    input  logic [IN_W-1:0]       value,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [STATUS_W-1:0]   status,
    input  logic [OUT_W-1:0]      value_res,
    input  logic                  last,
    output int unsigned           mismatches,
    output int unsigned           beats_owed
);

    typedef struct packed {
        status_t          st;
        logic [OUT_W-1:0] val;
        logic             lst;
    } dump_beat_t;

    // Predicted beats in order, held in a ring well above one full dump
    localparam int DUE_DEPTH = 128;
    localparam int DUE_W     = $clog2(DUE_DEPTH);

    dump_beat_t            due_ring [DUE_DEPTH];
    logic [DUE_W-1:0]      due_wr    = '0;
    logic [DUE_W-1:0]      due_rd    = '0;
    int unsigned           due_count = 0;
    int unsigned           owed_reg  = 0;

    // Shadow copy of the deque
    logic [VALUE_BITS-1:0] ring [DEPTH];
    logic [PTR_W-1:0]      head      = '0;
    logic [CNT_W-1:0]      count     = '0;
    logic                  reversed  = 1'b0;
    logic                  in_error  = 1'b0;

    int unsigned mismatch_total = 0;

    assign mismatches = mismatch_total;
    assign beats_owed = owed_reg;

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        mismatch_total++;
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    task automatic add_due_beat(input dump_beat_t beat);
        due_ring[due_wr] = beat;
        due_wr           = due_wr + DUE_W'(1);
        due_count++;
    endtask

    task automatic take_due_beat(output dump_beat_t beat);
        beat   = due_ring[due_rd];
        due_rd = due_rd + DUE_W'(1);
        due_count--;
    endtask

    function automatic logic [PTR_W-1:0] slot(input int off);
        return PTR_W'((int'(head) + off) % DEPTH);
    endfunction

    task automatic apply_command(input logic [MODE_W-1:0] cmd, input logic [IN_W-1:0] data);
        dump_beat_t beat;
        int         off;
        case (cmd)
            MODE_CLEAR:
            begin
                head     = '0;
                count    = '0;
                reversed = 1'b0;
                in_error = 1'b0;
            end
            MODE_LOAD:
            begin
                if (count < CNT_W'(DEPTH))
                begin
                    ring[slot(int'(count))] = VALUE_BITS'(data);
                    count = count + CNT_W'(1);
                end
            end
            MODE_REVERSE:
            begin
                if (!in_error)
                    reversed = !reversed;
            end
            MODE_DELETE:
            begin
                if (!in_error)
                begin
                    if (count == 0)
                        in_error = 1'b1;
                    else
                    begin
                        if (!reversed)
                            head = slot(1);
                        count = count - CNT_W'(1);
                    end
                end
            end
            MODE_DUMP:
            begin
                if (in_error)
                begin
                    beat = '{st: ST_ERROR, val: '0, lst: 1'b1};
                    add_due_beat(beat);
                end
                else if (count == 0)
                begin
                    beat = '{st: ST_EMPTY, val: '0, lst: 1'b1};
                    add_due_beat(beat);
                end
                else
                begin
                    for (int k = 0; k < int'(count); k++)
                    begin
                        off = reversed ? int'(count) - 1 - k : k;
                        beat.st  = ST_ELEM;
                        beat.val = OUT_W'(ring[slot(off)]);
                        beat.lst = (k == int'(count) - 1);
                        add_due_beat(beat);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin : watch
        dump_beat_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_count == 0)
                    report_mismatch("unexpected result, value_res", value_res, '0);
                else
                begin
                    take_due_beat(want);
                    if (status !== want.st)
                        report_mismatch("status", OUT_W'(status), OUT_W'(want.st));
                    if (value_res !== want.val)
                        report_mismatch("value_res", value_res, want.val);
                    if (last !== want.lst)
                        report_mismatch("last", OUT_W'(last), OUT_W'(want.lst));
                end
            end
            if (in_valid && in_ready)
                apply_command(mode, value);
            owed_reg <= due_count;
        end
    end

endmodule

// ===== tb/sv/reversible_deque_engine_test.sv =====
// Top of the reversible deque engine testbench: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict.
// Depends on rde_pkg, reversible_deque_engine and rde_dump_checker.
`timescale 1ns / 100ps

module reversible_deque_engine_test;
    import rde_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int DIRECTED_CMDS = 25;
    localparam int RANDOM_CMDS   = 400;
    localparam int MAX_IDLE      = 6;
    // Longest correct quiet spell is a drawn stall of up to MAX_IDLE plus the dump latency;
    // this is many times that.
    localparam int QUIET_LIMIT   = 200;
    // Wait after the final drain before the verdict.
    localparam int SETTLE_CYCLES = 8;
    localparam int FILL_BURST    = DEPTH + 2;

    // Modes the block decodes as no-ops
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [MODE_W-1:0]     mode      = MODE_CLEAR;
    logic [IN_W-1:0]       value     = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [OUT_W-1:0]      value_res;
    logic                  last;

    int unsigned fail_count;
    int unsigned beats_owed;

    // Both sides idle only while this is set; clearing it gives back-to-back stretches.
    logic        idle_on   = 1'b1;
    int unsigned cmds_sent = 0;
    int unsigned fills     = 0;
    int unsigned quiet     = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    reversible_deque_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .value_res (value_res),
        .last      (last)
    );

    rde_dump_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .value_res  (value_res),
        .last       (last),
        .mismatches (fail_count),
        .beats_owed (beats_owed)
    );

    // Drive one command beat and hold it until the block takes it. Valid drops
    // only for a drawn gap, so it is never lowered and raised in the same step.
    task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [IN_W-1:0] v);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        // Ignored modes do not count toward the stimulus total
        if (m <= MODE_DUMP)
            cmds_sent++;
    endtask

    // Hold off the command side until every predicted dump beat has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_owed != 0)
            @(posedge clk);
    endtask

    // One command of a well-formed sequence; loads and deletes dominate,
    // with a little noise from clears and the unused modes.
    task automatic send_random_op();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 6)
            send_cmd(MODE_LOAD, IN_W'($urandom));
        else if (pick < 8)
            send_cmd(MODE_REVERSE, IN_W'($urandom));
        else if (pick < 12)
            send_cmd(MODE_DELETE, IN_W'($urandom));
        else if (pick < 14)
            send_cmd(MODE_DUMP, IN_W'($urandom));
        else if (pick < 15)
            send_cmd(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), IN_W'($urandom));
        else
            send_cmd(MODE_CLEAR, IN_W'($urandom));
    endtask

    // Fill past full to hit saturation, then walk the head around the ring.
    task automatic send_fill_sequence();
        send_cmd(MODE_CLEAR, IN_W'($urandom));
        repeat (FILL_BURST) send_cmd(MODE_LOAD, IN_W'($urandom));
        send_cmd(MODE_DUMP, IN_W'($urandom));
        send_cmd(MODE_REVERSE, IN_W'($urandom));
        send_cmd(MODE_DUMP, IN_W'($urandom));
        send_cmd(MODE_REVERSE, IN_W'($urandom));
        repeat (5) send_cmd(MODE_DELETE, IN_W'($urandom));
        repeat (3) send_cmd(MODE_LOAD, IN_W'($urandom));
        send_cmd(MODE_DUMP, IN_W'($urandom));
    endtask

    // Short sequence: seed a few elements, mix operations, finish with a dump.
    task automatic send_short_sequence();
        int seeds;
        int ops;
        if ($urandom_range(0, 1) == 0)
            send_cmd(MODE_CLEAR, IN_W'($urandom));
        seeds = $urandom_range(0, 8);
        ops   = $urandom_range(3, 10);
        repeat (seeds) send_cmd(MODE_LOAD, IN_W'($urandom));
        repeat (ops) send_random_op();
        send_cmd(MODE_DUMP, IN_W'($urandom));
    endtask

    // Result side: draw a stall per beat, then hold ready until a beat is taken.
    initial
    begin : result_side
        int stall;
        repeat (RESET_CYCLES) @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty and error dumps, commands while in error,
        // value extremes, both orientations, delete from each end, unused modes.
        send_cmd(MODE_DUMP,    16'h1234);
        send_cmd(MODE_DELETE,  16'hFFFF);
        send_cmd(MODE_DUMP,    16'h0000);
        send_cmd(MODE_REVERSE, 16'h0000);
        send_cmd(MODE_DELETE,  16'h0000);
        send_cmd(MODE_LOAD,    16'hFFFF);
        send_cmd(MODE_DUMP,    16'h0000);
        send_cmd(MODE_CLEAR,   16'hFFFF);
        send_cmd(MODE_DUMP,    16'h0000);
        send_cmd(MODE_LOAD,    16'h0000);
        send_cmd(MODE_LOAD,    16'hFFFF);
        send_cmd(MODE_LOAD,    16'h5AA5);
        send_cmd(MODE_DUMP,    16'hFFFF);
        send_cmd(MODE_REVERSE, 16'hFFFF);
        send_cmd(MODE_DUMP,    16'h0000);
        send_cmd(MODE_DELETE,  16'h0000);
        send_cmd(MODE_DUMP,    16'h0000);
        send_cmd(MODE_REVERSE, 16'h0000);
        send_cmd(MODE_DELETE,  16'hFFFF);
        send_cmd(MODE_DUMP,    16'h0000);
        for (int s = MODE_SPARE_LO; s <= MODE_SPARE_HI; s++)
            send_cmd(MODE_W'(s), 16'hFFFF);
        send_cmd(MODE_DUMP,    16'h0000);
        send_cmd(MODE_CLEAR,   16'h0000);
        drain();

        // Random: mostly well-formed sequences, up to two fills to saturation.
        while (cmds_sent < DIRECTED_CMDS + RANDOM_CMDS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (fills < 2 && $urandom_range(0, 7) == 0)
            begin
                send_fill_sequence();
                fills++;
            end
            else
                send_short_sequence();
            if ($urandom_range(0, 5) == 0)
                drain();
        end

        idle_on = 1'b1;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rde_pkg.sv
rtl/core/rde_ram.sv
rtl/core/reversible_deque_engine.sv
tb/sv/rde_dump_checker.sv
tb/sv/reversible_deque_engine_test.sv
